FILE: rtl/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg: shared types and constants of the command frame builder
// Frame kinds, command codes, payload lengths, the frame descriptor passed
// from the front end to the serializer, and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package cfb_pkg;

  // Frame kinds as they arrive in the cmd field.
  typedef enum logic [2:0] {
    CMD_MASK     = 3'd0,
    CMD_VEL2     = 3'd1,
    CMD_VEL3     = 3'd2,
    CMD_SPD_STR  = 3'd3,
    CMD_THR_STR  = 3'd4,
    CMD_STATUS   = 3'd5,
    CMD_LIGHTS   = 3'd6,
    CMD_HEARTBT  = 3'd7
  } cmd_t;

  // Command codes placed fourth in the frame.
  localparam logic [7:0] CODE_MASK    = 8'h26;
  localparam logic [7:0] CODE_VEL2    = 8'h0F;
  localparam logic [7:0] CODE_VEL3    = 8'h0E;
  localparam logic [7:0] CODE_STEER   = 8'h0C;
  localparam logic [7:0] CODE_STATUS  = 8'h04;
  localparam logic [7:0] CODE_LIGHTS  = 8'h15;
  localparam logic [7:0] CODE_HEARTBT = 8'h70;

  // Payload lengths in bytes.
  localparam logic [7:0] LEN_SHORT = 8'h08;
  localparam logic [7:0] LEN_VEL3  = 8'h0C;
  localparam logic [7:0] LEN_STEER = 8'h11;

  localparam logic [7:0] HDR_SYNC0 = 8'hFF;
  localparam logic [7:0] HDR_SYNC1 = 8'hAA;
  localparam int         HDR_BYTES = 6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Largest payload and largest frame body ahead of the CRC.
  localparam int PAYLOAD_MAX = 17;
  localparam int DATA_MAX    = HDR_BYTES + PAYLOAD_MAX;
  localparam int COUNT_W     = $clog2(DATA_MAX + 1);

  // Depth of the queue between front end and serializer.
  localparam int QUEUE_DEPTH = 2;

  // One frame body, byte 0 in bits 7..0, plus its byte count.
  typedef struct packed {
    logic [DATA_MAX*8-1:0] bytes;
    logic [COUNT_W-1:0]    count;
  } frame_desc_t;

  // CRC-16 update over one byte, LSB first, reflected polynomial.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cfb_if.sv
// ----------------------------------------------------------------------------
// cfb_if: stream interfaces of the command frame builder
// cfb_req_if carries command requests, cfb_byte_if carries frame bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfb_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [7:0]         mode_byte;
  logic [7:0]         motor_byte;
  logic [31:0]        mask_bits;
  logic signed [31:0] value_a;
  logic signed [31:0] value_b;
  logic signed [31:0] value_c;
  logic [15:0]        throttle_value;
  logic [15:0]        brake_value;

  modport source (output valid, cmd, mode_byte, motor_byte, mask_bits, value_a,
                  value_b, value_c, throttle_value, brake_value, input ready);
  modport sink   (input valid, cmd, mode_byte, motor_byte, mask_bits, value_a,
                  value_b, value_c, throttle_value, brake_value, output ready);
endinterface

interface cfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/command_frame_builder_crc16_top.sv
// ----------------------------------------------------------------------------
// command_frame_builder_crc16_top: serial command framer with CRC-16
// Turns command requests into serial frames emitted one byte per transaction.
// ----------------------------------------------------------------------------
// Each accepted request on req produces one frame on frm: FF, AA, the device
// address, the command code, the 16-bit payload length low byte first, the
// payload with multi-byte words low byte first, and a CRC-16 (init FFFF,
// reflected polynomial A001) of all preceding bytes, sent low byte first with
// last_byte set on its final byte. Frames are 16, 20 or 25 bytes long. The
// serializer sends one byte per clock when frm is ready, and passes through
// its idle state between frames to fetch the next frame from the queue. The
// front end assembles a frame in the cycle its request is accepted and
// stores it in a two-entry queue, so up to two requests are taken while a
// frame is still going out. The device address register resets to 7F and
// is written through cfg_wr_en and cfg_wr_data; it should only be changed
// while no frame is pending.
`default_nettype none

module command_frame_builder_crc16_top (
  input  logic       clk,
  input  logic       rst,
  cfb_req_if.sink    req,
  cfb_byte_if.source frm,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import cfb_pkg::*;

  logic [7:0]  device_address;
  logic        push;
  logic        pop;
  logic        queue_full;
  logic        queue_empty;
  frame_desc_t push_desc;
  frame_desc_t pop_desc;

  // Address byte placed third in every frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'h7F;
    end else if (cfg_wr_en) begin
      device_address <= cfg_wr_data;
    end
  end

  // Front end: accepts a request and lays out the frame body.
  cfb_front u_front (
    .req            (req),
    .device_address (device_address),
    .queue_full     (queue_full),
    .push           (push),
    .desc           (push_desc)
  );

  // Queue decoupling request acceptance from byte output.
  cfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  // Back end: streams the bytes and appends the CRC.
  cfb_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .desc        (pop_desc),
    .pop         (pop),
    .frm         (frm)
  );

endmodule

`default_nettype wire

FILE: rtl/cfb_front.sv
// ----------------------------------------------------------------------------
// cfb_front: request acceptance and frame assembly
// Classifies each request by kind and lays out the frame body ahead of the CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_front (
  cfb_req_if.sink             req,
  input  logic [7:0]          device_address,
  input  logic                queue_full,
  output logic                push,
  output cfb_pkg::frame_desc_t desc
);
  import cfb_pkg::*;

  localparam int PL_W = PAYLOAD_MAX * 8;

  logic [7:0]      code;
  logic [7:0]      len;
  logic [PL_W-1:0] payload;

  assign req.ready = !queue_full;
  assign push      = req.valid && !queue_full;

  always_comb begin
    unique case (cmd_t'(req.cmd))
      CMD_MASK: begin
        code    = CODE_MASK;
        len     = LEN_SHORT;
        payload = PL_W'({32'hFFFF_FFFF, req.mask_bits});
      end
      CMD_VEL2: begin
        code    = CODE_VEL2;
        len     = LEN_SHORT;
        payload = PL_W'({req.value_b, req.value_a});
      end
      CMD_VEL3: begin
        code    = CODE_VEL3;
        len     = LEN_VEL3;
        payload = PL_W'({req.value_c, req.value_b, req.value_a});
      end
      CMD_SPD_STR: begin
        code    = CODE_STEER;
        len     = LEN_STEER;
        payload = {req.value_c, req.value_b, req.value_a, 32'h0, req.mode_byte};
      end
      CMD_THR_STR: begin
        code    = CODE_STEER;
        len     = LEN_STEER;
        payload = {req.value_c, req.value_b, req.value_a, req.brake_value,
                   req.throttle_value, req.mode_byte};
      end
      CMD_STATUS: begin
        code    = CODE_STATUS;
        len     = LEN_SHORT;
        payload = PL_W'({40'h0, req.motor_byte, 8'hFF, req.mode_byte});
      end
      CMD_LIGHTS: begin
        code    = CODE_LIGHTS;
        len     = LEN_SHORT;
        payload = PL_W'({req.value_b, req.value_a});
      end
      CMD_HEARTBT: begin
        code    = CODE_HEARTBT;
        len     = LEN_SHORT;
        payload = '0;
      end
    endcase
  end

  // Byte 0 of the frame sits in the low bits; the length goes low byte first.
  assign desc.bytes = {payload, 8'h00, len, code, device_address, HDR_SYNC1, HDR_SYNC0};
  assign desc.count = COUNT_W'(HDR_BYTES) + COUNT_W'(len);

endmodule

`default_nettype wire

FILE: rtl/cfb_queue.sv
// ----------------------------------------------------------------------------
// cfb_queue: frame descriptor queue
// A short first-in first-out buffer between the front end and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cfb_pkg::frame_desc_t push_desc,
  input  logic                 pop,
  output cfb_pkg::frame_desc_t pop_desc,
  output logic                 full,
  output logic                 empty
);
  import cfb_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  frame_desc_t     entries [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;

  assign full     = (fill == CW'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_desc = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cfb_serializer.sv
// ----------------------------------------------------------------------------
// cfb_serializer: byte serializer with CRC-16
// Sends a frame body one byte per transaction, then the CRC low and high bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_serializer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 queue_empty,
  input  cfb_pkg::frame_desc_t desc,
  output logic                 pop,
  cfb_byte_if.source           frm
);
  import cfb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_CRC_LO,
    ST_CRC_HI
  } state_t;

  state_t                state;
  logic [DATA_MAX*8-1:0] shreg;
  logic [COUNT_W-1:0]    remaining;
  logic [15:0]           crc;
  logic                  out_valid;
  logic [7:0]            out_byte;
  logic                  out_last;
  logic                  advance;

  // The output register can take a new byte when empty or being drained.
  assign advance = !out_valid || frm.ready;
  assign pop     = (state == ST_IDLE) && !queue_empty;

  assign frm.valid      = out_valid;
  assign frm.frame_byte = out_byte;
  assign frm.last_byte  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && frm.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!queue_empty) begin
            shreg     <= desc.bytes;
            remaining <= desc.count;
            crc       <= CRC_INIT;
            state     <= ST_DATA;
          end
        end
        ST_DATA: begin
          if (advance) begin
            out_valid <= 1'b1;
            out_byte  <= shreg[7:0];
            out_last  <= 1'b0;
            crc       <= crc16_byte(crc, shreg[7:0]);
            shreg     <= shreg >> 8;
            remaining <= remaining - 1'b1;
            if (remaining == COUNT_W'(1)) begin
              state <= ST_CRC_LO;
            end
          end
        end
        ST_CRC_LO: begin
          if (advance) begin
            out_valid <= 1'b1;
            out_byte  <= crc[7:0];
            out_last  <= 1'b0;
            state     <= ST_CRC_HI;
          end
        end
        ST_CRC_HI: begin
          if (advance) begin
            out_valid <= 1'b1;
            out_byte  <= crc[15:8];
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: verif/cfb_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_frame_checker: frame predictor and byte comparator
// Watches the request and frame channels, builds the expected frame for
// every accepted request, and compares each outgoing byte in order.
// ----------------------------------------------------------------------------

module cfb_frame_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  cfb_req_if         req_mon,
  cfb_byte_if        frm_mon,
  output int         mismatches,
  output int         bytes_due,
  output int         bytes_checked
);
  import cfb_pkg::*;

  localparam logic [7:0]  ADDRESS_RESET = 8'h7F;
  localparam logic [7:0]  SYNC_FIRST    = 8'hFF;
  localparam logic [7:0]  SYNC_SECOND   = 8'hAA;
  localparam logic [15:0] CRC_SEED      = 16'hFFFF;
  localparam logic [15:0] CRC_REFLECTED = 16'hA001;
  localparam int          REPORT_LIMIT  = 10;
  localparam int          FRAME_BYTES   = DATA_MAX + 2;

  localparam logic [7:0] FRAME_CODE_MASK      = 8'h26;
  localparam logic [7:0] FRAME_CODE_VEL2      = 8'h0F;
  localparam logic [7:0] FRAME_CODE_VEL3      = 8'h0E;
  localparam logic [7:0] FRAME_CODE_STEER     = 8'h0C;
  localparam logic [7:0] FRAME_CODE_STATUS    = 8'h04;
  localparam logic [7:0] FRAME_CODE_LIGHTS    = 8'h15;
  localparam logic [7:0] FRAME_CODE_HEARTBEAT = 8'h70;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic [7:0]  address_reg;
  frame_byte_t frame_bytes_due[$];

  // Bit-serial form of the reflected CRC-16: one data bit per shift.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        feedback;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      feedback = c[0] ^ data[i];
      c = {1'b0, c[15:1]};
      if (feedback) begin
        c = c ^ CRC_REFLECTED;
      end
    end
    return c;
  endfunction

  // Assemble the whole frame for one request and queue its bytes.
  function automatic void expect_frame(input cmd_t kind, input logic [7:0] mode,
                                       input logic [7:0] motor, input logic [31:0] mask,
                                       input logic [31:0] va, input logic [31:0] vb,
                                       input logic [31:0] vc, input logic [15:0] thr,
                                       input logic [15:0] brk);
    logic [7:0]   code;
    logic [135:0] payload;
    logic [15:0]  plen;
    logic [7:0]   body [FRAME_BYTES];
    int           body_len;
    frame_byte_t  entry;
    logic [15:0]  crc;
    payload = '0;
    plen    = 16'd8;
    case (kind)
      CMD_MASK: begin
        code    = FRAME_CODE_MASK;
        payload = {32'hFFFF_FFFF, mask};
      end
      CMD_VEL2: begin
        code    = FRAME_CODE_VEL2;
        payload = {vb, va};
      end
      CMD_VEL3: begin
        code    = FRAME_CODE_VEL3;
        payload = {vc, vb, va};
        plen    = 16'd12;
      end
      CMD_SPD_STR: begin
        code    = FRAME_CODE_STEER;
        payload = {vc, vb, va, 32'h0, mode};
        plen    = 16'd17;
      end
      CMD_THR_STR: begin
        code    = FRAME_CODE_STEER;
        payload = {vc, vb, va, brk, thr, mode};
        plen    = 16'd17;
      end
      CMD_STATUS: begin
        code    = FRAME_CODE_STATUS;
        payload = {8'h00, motor, 8'hFF, mode};
      end
      CMD_LIGHTS: begin
        code    = FRAME_CODE_LIGHTS;
        payload = {vb, va};
      end
      default: begin
        code = FRAME_CODE_HEARTBEAT;
      end
    endcase
    body[0]  = SYNC_FIRST;
    body[1]  = SYNC_SECOND;
    body[2]  = address_reg;
    body[3]  = code;
    body[4]  = plen[7:0];
    body[5]  = plen[15:8];
    body_len = 6;
    for (int k = 0; k < int'(plen); k++) begin
      body[body_len] = payload[8*k +: 8];
      body_len++;
    end
    crc = CRC_SEED;
    for (int k = 0; k < body_len; k++) begin
      crc = crc_step(crc, body[k]);
    end
    body[body_len]     = crc[7:0];
    body[body_len + 1] = crc[15:8];
    body_len           = body_len + 2;
    for (int k = 0; k < body_len; k++) begin
      entry.data = body[k];
      entry.last = (k == body_len - 1);
      frame_bytes_due.insert(frame_bytes_due.size(), entry);
    end
  endfunction

  function automatic void report_mismatch(input string what, input frame_byte_t due);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s: expected byte %h last %b, got byte %h last %b", $time, what,
               due.data, due.last, frm_mon.frame_byte, frm_mon.last_byte);
    end
  endfunction

  always @(posedge clk) begin
    frame_byte_t due;
    if (rst) begin
      address_reg = ADDRESS_RESET;
      frame_bytes_due.delete();
      mismatches    = 0;
      bytes_due     = 0;
      bytes_checked = 0;
    end else begin
      // Compare first so that a byte can never match a frame accepted at this edge.
      if (frm_mon.valid && frm_mon.ready) begin
        bytes_checked++;
        if (frame_bytes_due.size() == 0) begin
          report_mismatch("byte with no frame pending", '0);
        end else begin
          due = frame_bytes_due.pop_front();
          if (due.data !== frm_mon.frame_byte || due.last !== frm_mon.last_byte) begin
            report_mismatch("frame byte mismatch", due);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expect_frame(cmd_t'(req_mon.cmd), req_mon.mode_byte, req_mon.motor_byte,
                     req_mon.mask_bits, req_mon.value_a, req_mon.value_b, req_mon.value_c,
                     req_mon.throttle_value, req_mon.brake_value);
      end
      if (cfg_wr_en) begin
        address_reg = cfg_wr_data;
      end
      bytes_due = frame_bytes_due.size();
    end
  end

endmodule

FILE: verif/tb_command_frame_builder_crc16_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_frame_builder_crc16_top: testbench of the command frame builder
// Sends directed and random command requests under several device addresses,
// with random stalls on both channels, and lets the frame checker compare
// every emitted byte against its own frame and CRC prediction.
// ----------------------------------------------------------------------------

module tb_command_frame_builder_crc16_top;
  import cfb_pkg::*;

  // The watchdog trips after this many cycles without any transaction. The
  // slowest legal pause is a sink stall on top of a source gap and the frame
  // fetch, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 1000;
  // Cycles allowed after the last expected byte to catch stray output.
  localparam int DRAIN_CYCLES   = 40;
  localparam int ADDRESS_PHASES = 6;
  localparam int PHASE_REQUESTS = 57;

  typedef struct {
    cmd_t        kind;
    logic [7:0]  mode;
    logic [7:0]  motor;
    logic [31:0] mask;
    logic [31:0] va;
    logic [31:0] vb;
    logic [31:0] vc;
    logic [15:0] throttle;
    logic [15:0] brake;
  } request_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  // Random stalls on both channels are allowed while this is high.
  logic       idle_allowed;

  int         mismatches;
  int         bytes_due;
  int         bytes_checked;
  int         requests_sent;
  int         address_writes;
  logic [7:0] kinds_seen;

  cfb_req_if  req ();
  cfb_byte_if frm ();

  command_frame_builder_crc16_top DUT (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .frm         (frm),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // The checker sits beside the block and sees exactly what crosses its ports.
  cfb_frame_checker frame_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .req_mon       (req),
    .frm_mon       (frm),
    .mismatches    (mismatches),
    .bytes_due     (bytes_due),
    .bytes_checked (bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic request_t make_request(input cmd_t kind, input logic [7:0] mode,
                                            input logic [7:0] motor, input logic [31:0] mask,
                                            input logic [31:0] va, input logic [31:0] vb,
                                            input logic [31:0] vc, input logic [15:0] throttle,
                                            input logic [15:0] brake);
    request_t r;
    r.kind     = kind;
    r.mode     = mode;
    r.motor    = motor;
    r.mask     = mask;
    r.va       = va;
    r.vb       = vb;
    r.vc       = vc;
    r.throttle = throttle;
    r.brake    = brake;
    return r;
  endfunction

  // Payload words lean toward the signed extremes and the all-zero and
  // all-one patterns, since those are where byte ordering errors show up.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Every field is randomized, including those the chosen kind ignores, so
  // that unused inputs are shown to have no effect on the frame.
  function automatic request_t random_request();
    return make_request(cmd_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), pick_word(), pick_word(), pick_word(),
                        pick_word(), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)));
  endfunction

  // Present one request and hold it until it is accepted. The valid stays
  // high afterwards unless an idle gap is drawn, so back-to-back requests
  // never see valid dropped and raised within one time step.
  task automatic send_request(input request_t r);
    req.valid          <= 1'b1;
    req.cmd            <= r.kind;
    req.mode_byte      <= r.mode;
    req.motor_byte     <= r.motor;
    req.mask_bits      <= r.mask;
    req.value_a        <= r.va;
    req.value_b        <= r.vb;
    req.value_c        <= r.vc;
    req.throttle_value <= r.throttle;
    req.brake_value    <= r.brake;
    do @(posedge clk); while (!req.ready);
    requests_sent++;
    kinds_seen[r.kind] = 1'b1;
    if (idle_allowed && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // The address may only change with no frame in flight, so the request
  // side is parked and every predicted byte must have gone out first.
  task automatic write_address(input logic [7:0] addr);
    req.valid <= 1'b0;
    while (bytes_due != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    address_writes++;
  endtask

  // Sink side: random bursts of back-pressure separated by ready stretches.
  initial begin
    frm.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_allowed && $urandom_range(0, 2) == 0) begin
        frm.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      frm.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // Watchdog: any transaction on either channel restarts the count.
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (frm.valid && frm.ready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("Watchdog: %0d cycles without a transaction, %0d bytes still due",
             stalled, bytes_due);
    $display("[command_frame_builder_crc16_top] ERROR");
    $finish;
  end

  initial begin
    logic [7:0] addr;
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= 8'h00;
    idle_allowed       <= 1'b1;
    req.valid          <= 1'b0;
    req.cmd            <= CMD_MASK;
    req.mode_byte      <= 8'h00;
    req.motor_byte     <= 8'h00;
    req.mask_bits      <= 32'h0;
    req.value_a        <= 32'h0;
    req.value_b        <= 32'h0;
    req.value_c        <= 32'h0;
    req.throttle_value <= 16'h0;
    req.brake_value    <= 16'h0;
    requests_sent  = 0;
    address_writes = 0;
    kinds_seen     = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part, under the reset address. Every kind is sent once with
    // all fields cleared and once with all fields set, the latter also
    // showing that fields a kind does not use are left out of its frame.
    for (int k = 0; k < 8; k++) begin
      send_request(make_request(cmd_t'(k), 8'h00, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0,
                                16'h0, 16'h0));
    end
    for (int k = 0; k < 8; k++) begin
      send_request(make_request(cmd_t'(k), 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    end
    // Signed extremes in each word position, and asymmetric values that
    // expose swapped bytes or swapped words.
    send_request(make_request(CMD_VEL3, 8'h00, 8'h00, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h8000_0000, 16'h0, 16'h0));
    send_request(make_request(CMD_THR_STR, 8'h80, 8'h00, 32'h0, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'h0000_0001, 16'hFFFF, 16'h0000));
    send_request(make_request(CMD_SPD_STR, 8'h01, 8'h00, 32'h0, 32'hFFFF_FC18,
                              32'h0000_03E8, 32'h7FFF_FFFF, 16'h1234, 16'h5678));
    send_request(make_request(CMD_MASK, 8'h00, 8'h00, 32'h8000_0001, 32'h0, 32'h0, 32'h0,
                              16'h0, 16'h0));
    send_request(make_request(CMD_STATUS, 8'h5A, 8'hA5, 32'h0, 32'h0, 32'h0, 32'h0,
                              16'h0, 16'h0));
    send_request(make_request(CMD_LIGHTS, 8'h00, 8'h00, 32'h0, 32'h0102_0304,
                              32'hF0E0_D0C0, 32'h0, 16'h0, 16'h0));

    // Random part: one phase per device address, the extremes first. The
    // last phase runs with no stalls at all so the block is seen at full rate.
    for (int phase = 0; phase < ADDRESS_PHASES; phase++) begin
      case (phase)
        0:       addr = 8'h00;
        1:       addr = 8'hFF;
        2:       addr = 8'h80;
        default: addr = 8'($urandom_range(0, 255));
      endcase
      if (phase == ADDRESS_PHASES - 1) begin
        idle_allowed <= 1'b0;
      end
      write_address(addr);
      repeat (PHASE_REQUESTS) send_request(random_request());
    end
    req.valid <= 1'b0;

    // Drain: every predicted byte must arrive, then a quiet window follows
    // in which any extra byte would be flagged by the checker.
    while (bytes_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests over %0d of 8 frame kinds, reset address plus %0d writes.",
             requests_sent, $countones(kinds_seen), address_writes);
    $display("Compared %0d frame bytes, %0d mismatches.", bytes_checked, mismatches);
    if (mismatches == 0 && bytes_due == 0) begin
      $display("[command_frame_builder_crc16_top] OK");
    end else begin
      $display("[command_frame_builder_crc16_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cfb_pkg.sv
rtl/cfb_if.sv
rtl/cfb_front.sv
rtl/cfb_queue.sv
rtl/cfb_serializer.sv
rtl/command_frame_builder_crc16_top.sv
verif/cfb_frame_checker.sv
verif/tb_command_frame_builder_crc16_top.sv
